### sv/rrqs_pkg.sv
// Package for the round-robin quantum scheduler.
// Holds table entry types, request and response types, sequencer states and saturating helpers.
// No dependencies.
package rrqs_pkg;

  localparam int unsigned MaxProcsDef = 16;

  localparam logic ActLoad = 1'b0;
  localparam logic ActTick = 1'b1;

  typedef struct packed {
    logic        action;
    logic [7:0]  proc_id;
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
  } req_t;

  typedef struct packed {
    logic        load_accepted;
    logic        running_valid;
    logic [7:0]  running_id;
    logic        finished_valid;
    logic [7:0]  finished_id;
    logic [31:0] finished_completion;
    logic [31:0] finished_waiting;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
  } pend_ent_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] burst;
    logic [15:0] done;
    logic [31:0] wait_cnt;
  } rdy_ent_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ADMIT,
    ST_DECIDE,
    ST_INSERT,
    ST_PICK,
    ST_PASS,
    ST_EXEC,
    ST_FIN
  } eng_state_e;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

### sv/rrqs_if.sv
// Request and response channel interfaces of the scheduler.
// Depends on nothing; valid/ready handshake with flat payload.
interface rrqs_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  proc_id;
  logic [15:0] arrival_time;
  logic [15:0] burst_time;

  modport source (output valid, action, proc_id, arrival_time, burst_time, input ready);
  modport sink (input valid, action, proc_id, arrival_time, burst_time, output ready);
endinterface

interface rrqs_rsp_if;
  logic        valid;
  logic        ready;
  logic        load_accepted;
  logic        running_valid;
  logic [7:0]  running_id;
  logic        finished_valid;
  logic [7:0]  finished_id;
  logic [31:0] finished_completion;
  logic [31:0] finished_waiting;

  modport source (output valid, load_accepted, running_valid, running_id, finished_valid,
                  finished_id, finished_completion, finished_waiting, input ready);
  modport sink (input valid, load_accepted, running_valid, running_id, finished_valid,
                finished_id, finished_completion, finished_waiting, output ready);
endinterface

### sv/rrqs_out_reg.sv
// Response output register of the scheduler.
// Depends on rrqs_pkg for the response type.
module rrqs_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rrqs_pkg::rsp_t data_i,
  output logic          free_o,
  output logic          valid_o,
  input  logic          ready_i,
  output rrqs_pkg::rsp_t data_o
);

  logic           valid_q, valid_d;
  rrqs_pkg::rsp_t data_q, data_d;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (valid_q && ready_i) begin
      valid_d = 1'b0;
    end
    if (push_i && free_o) begin
      valid_d = 1'b1;
      data_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/rrqs_engine.sv
// Scheduler sequencer with the pending and ready tables in synchronous memories.
// Depends on rrqs_pkg for entry types, states and saturating helpers.
module rrqs_engine #(
  parameter int unsigned MAX_PROCS = rrqs_pkg::MaxProcsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  rrqs_pkg::req_t req_i,
  input  logic [15:0]    quantum_i,
  input  logic           slot_free_i,
  output logic           push_o,
  output rrqs_pkg::rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(MAX_PROCS + 1);
  localparam int unsigned IW = $clog2(MAX_PROCS);
  localparam int unsigned QW = CW + 1;
  localparam logic signed [QW-1:0] QOne = QW'(1);

  rrqs_pkg::eng_state_e state_q, state_d;

  rrqs_pkg::pend_ent_t pend_mem [MAX_PROCS];
  rrqs_pkg::rdy_ent_t  rdy_mem  [MAX_PROCS];
  rrqs_pkg::pend_ent_t pend_rdata_q, pend_wdata;
  rrqs_pkg::rdy_ent_t  rdy_rdata_q, rdy_wdata;
  logic                pend_re, pend_we, rdy_re, rdy_we;
  logic [IW-1:0]       pend_raddr, pend_waddr, rdy_raddr, rdy_waddr;

  rrqs_pkg::req_t req_q, req_d;
  rrqs_pkg::rsp_t res_q, res_d;

  logic [CW-1:0]        pc_q, pc_d, rc_q, rc_d;
  logic                 run_q, run_d;
  rrqs_pkg::rdy_ent_t   run_ent_q, run_ent_d;
  logic signed [QW-1:0] qp_q, qp_d;
  logic [15:0]          slice_q, slice_d;
  logic [31:0]          step_q, step_d;
  logic [CW-1:0]        rd_q, rd_d, wr_q, wr_d, pa_q, pa_d;
  logic                 pv_q, pv_d;
  logic [CW-1:0]        ins_p_q, ins_p_d, rm_idx_q, rm_idx_d;
  logic                 rm_q, rm_d;

  logic [CW:0]          total;
  logic [CW-1:0]        rd_dec, pa_inc, clamp_p;
  logic signed [QW-1:0] qn, rc_s;

  assign total  = {1'b0, pc_q} + {1'b0, rc_q} + {{CW{1'b0}}, run_q};
  assign rd_dec = rd_q - 1'b1;
  assign pa_inc = pa_q + 1'b1;
  assign rc_s   = $signed({1'b0, rc_q});

  always_comb begin
    if (qp_q < 0) begin
      clamp_p = '0;
    end else if (qp_q > rc_s) begin
      clamp_p = rc_q;
    end else begin
      clamp_p = qp_q[CW-1:0];
    end
    qn = qp_q + QOne;
    if (qn < 0 || qn >= rc_s) begin
      qn = '0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rrqs_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          state_d = (req_i.action == rrqs_pkg::ActLoad) ? rrqs_pkg::ST_LOAD
                                                        : rrqs_pkg::ST_ADMIT;
        end
      end
      rrqs_pkg::ST_LOAD: state_d = rrqs_pkg::ST_FIN;
      rrqs_pkg::ST_ADMIT: begin
        if (rd_q == pc_q && !pv_q) state_d = rrqs_pkg::ST_DECIDE;
      end
      rrqs_pkg::ST_DECIDE: begin
        if (!run_q || run_ent_q.done >= run_ent_q.burst) begin
          state_d = rrqs_pkg::ST_PICK;
        end else if (slice_q >= quantum_i) begin
          state_d = rrqs_pkg::ST_INSERT;
        end else begin
          state_d = rrqs_pkg::ST_PASS;
        end
      end
      rrqs_pkg::ST_INSERT: begin
        if (rd_q == ins_p_q && !pv_q) state_d = rrqs_pkg::ST_PICK;
      end
      rrqs_pkg::ST_PICK: state_d = rrqs_pkg::ST_PASS;
      rrqs_pkg::ST_PASS: begin
        if (rd_q == rc_q && !pv_q) state_d = rrqs_pkg::ST_EXEC;
      end
      rrqs_pkg::ST_EXEC: state_d = rrqs_pkg::ST_FIN;
      rrqs_pkg::ST_FIN: begin
        if (slot_free_i) state_d = rrqs_pkg::ST_IDLE;
      end
      default: state_d = rrqs_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_d     = req_q;
    res_d     = res_q;
    pc_d      = pc_q;
    rc_d      = rc_q;
    run_d     = run_q;
    run_ent_d = run_ent_q;
    qp_d      = qp_q;
    slice_d   = slice_q;
    step_d    = step_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    pa_d      = pa_q;
    pv_d      = pv_q;
    ins_p_d   = ins_p_q;
    rm_d      = rm_q;
    rm_idx_d  = rm_idx_q;
    pend_re    = 1'b0;
    pend_raddr = rd_q[IW-1:0];
    pend_we    = 1'b0;
    pend_waddr = wr_q[IW-1:0];
    pend_wdata = pend_rdata_q;
    rdy_re     = 1'b0;
    rdy_raddr  = rd_q[IW-1:0];
    rdy_we     = 1'b0;
    rdy_waddr  = wr_q[IW-1:0];
    rdy_wdata  = rdy_rdata_q;
    push_o     = 1'b0;

    case (state_q)
      rrqs_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          req_d = req_i;
          res_d = '0;
          rd_d  = '0;
          wr_d  = '0;
          pv_d  = 1'b0;
        end
      end
      rrqs_pkg::ST_LOAD: begin
        if (total < (CW + 1)'(MAX_PROCS) && pc_q < CW'(MAX_PROCS)) begin
          pend_we    = 1'b1;
          pend_waddr = pc_q[IW-1:0];
          pend_wdata = '{id: req_q.proc_id, arrival: req_q.arrival_time,
                         burst: req_q.burst_time};
          pc_d       = pc_q + 1'b1;
          res_d.load_accepted = 1'b1;
        end
      end
      rrqs_pkg::ST_ADMIT: begin
        pv_d = 1'b0;
        if (rd_q < pc_q) begin
          pend_re = 1'b1;
          rd_d    = rd_q + 1'b1;
          pv_d    = 1'b1;
        end
        if (pv_q) begin
          if ({16'd0, pend_rdata_q.arrival} <= step_q && rc_q < CW'(MAX_PROCS)) begin
            rdy_we    = 1'b1;
            rdy_waddr = rc_q[IW-1:0];
            rdy_wdata = '{id: pend_rdata_q.id, burst: pend_rdata_q.burst,
                          done: 16'd0, wait_cnt: 32'd0};
            rc_d      = rc_q + 1'b1;
          end else begin
            pend_we = 1'b1;
            wr_d    = wr_q + 1'b1;
          end
        end
        if (rd_q == pc_q && !pv_q) begin
          pc_d = wr_q;
        end
      end
      rrqs_pkg::ST_DECIDE: begin
        rm_d = 1'b0;
        rd_d = '0;
        wr_d = '0;
        pv_d = 1'b0;
        if (run_q) begin
          if (run_ent_q.done >= run_ent_q.burst) begin
            res_d.finished_valid      = 1'b1;
            res_d.finished_id         = run_ent_q.id;
            res_d.finished_completion = step_q;
            res_d.finished_waiting    = run_ent_q.wait_cnt;
            run_d = 1'b0;
            qp_d  = qp_q - QOne;
          end else if (slice_q >= quantum_i) begin
            rd_d    = rc_q;
            ins_p_d = clamp_p;
            run_d   = 1'b0;
          end
        end
      end
      rrqs_pkg::ST_INSERT: begin
        pv_d = 1'b0;
        if (rd_q > ins_p_q) begin
          rdy_re    = 1'b1;
          rdy_raddr = rd_dec[IW-1:0];
          rd_d      = rd_dec;
          pa_d      = rd_dec;
          pv_d      = 1'b1;
        end
        if (pv_q) begin
          rdy_we    = 1'b1;
          rdy_waddr = pa_inc[IW-1:0];
        end
        if (rd_q == ins_p_q && !pv_q) begin
          rdy_we    = 1'b1;
          rdy_waddr = ins_p_q[IW-1:0];
          rdy_wdata = run_ent_q;
          rc_d      = rc_q + 1'b1;
        end
      end
      rrqs_pkg::ST_PICK: begin
        qp_d     = qn;
        slice_d  = '0;
        rm_d     = (rc_q != '0);
        rm_idx_d = qn[CW-1:0];
        rd_d     = '0;
        wr_d     = '0;
        pv_d     = 1'b0;
      end
      rrqs_pkg::ST_PASS: begin
        pv_d = 1'b0;
        if (rd_q < rc_q) begin
          rdy_re = 1'b1;
          rd_d   = rd_q + 1'b1;
          pa_d   = rd_q;
          pv_d   = 1'b1;
        end
        if (pv_q) begin
          if (rm_q && pa_q == rm_idx_q) begin
            run_d     = 1'b1;
            run_ent_d = rdy_rdata_q;
          end else begin
            rdy_we             = 1'b1;
            rdy_wdata.wait_cnt = rrqs_pkg::sat_inc32(rdy_rdata_q.wait_cnt);
            wr_d               = wr_q + 1'b1;
          end
        end
        if (rd_q == rc_q && !pv_q) begin
          rc_d = wr_q;
        end
      end
      rrqs_pkg::ST_EXEC: begin
        if (run_q) begin
          run_ent_d.done      = rrqs_pkg::sat_inc16(run_ent_q.done);
          slice_d             = rrqs_pkg::sat_inc16(slice_q);
          res_d.running_valid = 1'b1;
          res_d.running_id    = run_ent_q.id;
        end
        step_d = rrqs_pkg::sat_inc32(step_q);
      end
      rrqs_pkg::ST_FIN: begin
        push_o = slot_free_i;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
    if (pend_re) pend_rdata_q <= pend_mem[pend_raddr];
    if (rdy_we) rdy_mem[rdy_waddr] <= rdy_wdata;
    if (rdy_re) rdy_rdata_q <= rdy_mem[rdy_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rrqs_pkg::ST_IDLE;
      pc_q    <= '0;
      rc_q    <= '0;
      run_q   <= 1'b0;
      qp_q    <= '1;
      slice_q <= '0;
      step_q  <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      pv_q    <= 1'b0;
      rm_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      rc_q    <= rc_d;
      run_q   <= run_d;
      qp_q    <= qp_d;
      slice_q <= slice_d;
      step_q  <= step_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      pv_q    <= pv_d;
      rm_q    <= rm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    res_q     <= res_d;
    run_ent_q <= run_ent_d;
    pa_q      <= pa_d;
    ins_p_q   <= ins_p_d;
    rm_idx_q  <= rm_idx_d;
  end

  assign req_ready_o = (state_q == rrqs_pkg::ST_IDLE);
  assign rsp_o       = res_q;

`ifndef SYNTHESIS
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rrqs_pkg::ST_IDLE |-> total <= (CW + 1)'(MAX_PROCS))
    else $error("scheduler occupancy exceeds table depth");

  a_qpos_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qp_q >= -1 && qp_q <= rc_s)
    else $error("queue position out of range");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rrqs_pkg::ST_IDLE && req_valid_i |=> state_q != rrqs_pkg::ST_IDLE)
    else $error("accepted request did not start");

  a_fin_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rrqs_pkg::ST_FIN && slot_free_i |=> state_q == rrqs_pkg::ST_IDLE)
    else $error("response push did not return to idle");
`endif

endmodule

### sv/round_robin_quantum_scheduler_core.sv
// Top level of the round-robin quantum scheduler.
// Depends on rrqs_pkg, rrqs_if, rrqs_engine and rrqs_out_reg.
//
// Usage: requests enter on req_i (valid/ready). action 0 loads a process
// (id, arrival step, burst) into the pending table; action 1 is one tick.
// Every request yields exactly one response on rsp_o (valid/ready).
// The quantum register is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while idle, which the block itself does not enforce.
// A load passes through the load and finish states. A tick sweeps the
// pending table, then the ready table, with one more ready sweep before
// it when the running process is preempted. Each table memory has a
// single read and a single write port, and every sweep goes through it
// one entry per cycle.
// One request is in work at a time; req_i.ready is high only when idle.
// A finished response waits in the output register; a new request is
// accepted while it waits, and the next response holds until it is taken.
// Reset empties both tables, clears the step counter and sets the
// quantum to 1; no clearing pass is needed.
module round_robin_quantum_scheduler_core #(
  parameter int unsigned MAX_PROCS = rrqs_pkg::MaxProcsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  rrqs_req_if.sink    req_i,
  rrqs_rsp_if.source  rsp_o
);

  logic [15:0]    quantum_q;
  rrqs_pkg::req_t req;
  rrqs_pkg::rsp_t eng_rsp, out_rsp;
  logic           push, slot_free, out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= 16'd1;
    end else if (cfg_we_i) begin
      quantum_q <= cfg_wdata_i;
    end
  end

  assign req = '{action: req_i.action, proc_id: req_i.proc_id,
                 arrival_time: req_i.arrival_time, burst_time: req_i.burst_time};

  rrqs_engine #(
    .MAX_PROCS(MAX_PROCS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .quantum_i   (quantum_q),
    .slot_free_i (slot_free),
    .push_o      (push),
    .rsp_o       (eng_rsp)
  );

  rrqs_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (eng_rsp),
    .free_o  (slot_free),
    .valid_o (out_valid),
    .ready_i (rsp_o.ready),
    .data_o  (out_rsp)
  );

  assign rsp_o.valid               = out_valid;
  assign rsp_o.load_accepted       = out_rsp.load_accepted;
  assign rsp_o.running_valid       = out_rsp.running_valid;
  assign rsp_o.running_id          = out_rsp.running_id;
  assign rsp_o.finished_valid      = out_rsp.finished_valid;
  assign rsp_o.finished_id         = out_rsp.finished_id;
  assign rsp_o.finished_completion = out_rsp.finished_completion;
  assign rsp_o.finished_waiting    = out_rsp.finished_waiting;

endmodule
